// ===== sv/pli_pkg.sv =====
// shared constants and types for the positional list block
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // default sizing of the list
   localparam int PLI_CAPACITY   = 16;
   localparam int PLI_ELEM_WIDTH = 32;

   // fixed field widths of the channel words
   localparam int PLI_ACTION_W = 2;
   localparam int PLI_POS_W    = 5;
   localparam int PLI_VALUE_W  = 32;
   localparam int PLI_COUNT_W  = 5;

   // width of position and length compares, covers a capacity up to 126 plus one
   localparam int PLI_IDX_W = 7;

   // request action codes
   typedef logic [PLI_ACTION_W-1:0] action_type;
   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_DELETE = 2'd1;
   localparam action_type ACT_PRINT  = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [PLI_IDX_W-1:0]   pos_idx;
      logic [PLI_IDX_W-1:0]   len;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== sv/pli_if.sv =====
// request and response channel interfaces of the positional list block
`timescale 1ns / 1ps
`default_nettype none

interface pli_req_if;
   import pli_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [PLI_ACTION_W-1:0]       action;
   logic [PLI_POS_W-1:0]          position;
   logic signed [PLI_VALUE_W-1:0] value;

   modport source (output valid, action, position, value, input ready);
   modport sink   (input valid, action, position, value, output ready);
endinterface

interface pli_rsp_if;
   import pli_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic signed [PLI_VALUE_W-1:0] value_out;
   logic [PLI_COUNT_W-1:0]        count;
   logic                          last;

   modport source (output valid, ok, value_out, count, last, input ready);
   modport sink   (input valid, ok, value_out, count, last, output ready);
endinterface

`default_nettype wire

// ===== sv/pli_cell.sv =====
// one storage cell of the list chain, holds the entry at a fixed position
`timescale 1ns / 1ps
`default_nettype none

module pli_cell #(
   parameter int ELEM_WIDTH = pli_pkg::PLI_ELEM_WIDTH,
   parameter int IDX        = 0
) (
   input  wire logic                  clock,
   input  wire pli_pkg::cell_cmd_type cmd,
   input  wire logic [ELEM_WIDTH-1:0] new_data,
   input  wire logic [ELEM_WIDTH-1:0] left_data,
   input  wire logic [ELEM_WIDTH-1:0] right_data,
   input  wire logic [ELEM_WIDTH-1:0] head_data,
   output logic      [ELEM_WIDTH-1:0] data_out
);
   import pli_pkg::*;

   localparam logic [PLI_IDX_W-1:0] MY_IDX  = PLI_IDX_W'(IDX);
   localparam logic [PLI_IDX_W-1:0] MY_NEXT = PLI_IDX_W'(IDX + 1);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;

   // pick the next word from the neighbors according to the broadcast op
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_IDX == cmd.pos_idx) begin
               data_in = new_data;
            end else if (MY_IDX > cmd.pos_idx) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= cmd.pos_idx) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // tail of the used part takes the head, the rest move forward
            if (MY_NEXT == cmd.len) begin
               data_in = head_data;
            end else if (MY_NEXT < cmd.len) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== sv/positional_list_insert_delete.sv =====
// top level of the positional list: control, length count and the cell chain
//
//   channel   dir  handshake       word
//   req_ch    in   valid / ready   action, position, value
//   rsp_ch    out  valid / ready   ok, value_out, count, last
//
// insert, delete and unused actions finish at the accept edge; the response word sits in
// the output register on the next cycle.
// print accepts the request, then steps once per stored entry whenever the output
// register is free (an empty list emits nothing): the head cell is emitted and the used
// part of the chain rotates by one, so it ends restored.
// reset clears length and control only; entries are never read unwritten.
// a stalled response holds the output register; no request is taken while
// the output register stays full or a print is streaming.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete #(
   parameter int CAPACITY   = pli_pkg::PLI_CAPACITY,
   parameter int ELEM_WIDTH = pli_pkg::PLI_ELEM_WIDTH
) (
   input wire logic  clock,
   input wire logic  reset,
   pli_req_if.sink   req_ch,
   pli_rsp_if.source rsp_ch
);
   import pli_pkg::*;

   localparam int LW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PRINT = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [LW-1:0]                 length_ff, length_in;
   logic [LW-1:0]                 prn_cnt_ff, prn_cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic signed [PLI_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PLI_COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   cell_cmd_type                  cmd;
   logic [ELEM_WIDTH-1:0]         cell_data [CAPACITY];
   logic [ELEM_WIDTH-1:0]         new_elem;
   logic [ELEM_WIDTH-1:0]         removed;

   logic                          slot_free;
   logic                          req_fire;
   logic [PLI_IDX_W-1:0]          pos_w;
   logic [PLI_IDX_W-1:0]          len_w;
   logic [PLI_IDX_W-1:0]          pos_idx;
   logic                          ins_ok;
   logic                          del_ok;
   logic                          prn_last;

   // handshake
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // position checks
   assign pos_w   = PLI_IDX_W'(req_ch.position);
   assign len_w   = PLI_IDX_W'(length_ff);
   assign pos_idx = pos_w - 1'b1;
   assign ins_ok  = (pos_w != '0) && (pos_w <= len_w + 1'b1)
                    && (len_w < PLI_IDX_W'(CAPACITY));
   assign del_ok  = (pos_w != '0) && (pos_w <= len_w);

   assign new_elem = ELEM_WIDTH'(req_ch.value);
   assign prn_last = (LW'(prn_cnt_ff + 1'b1) == length_ff);

   // word leaving the chain on a delete
   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (PLI_IDX_W'(i) == pos_idx) begin
            removed = removed | cell_data[i];
         end
      end
   end

   // sequencer and response word
   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      prn_cnt_in   = prn_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      cmd.op       = CELL_HOLD;
      cmd.pos_idx  = pos_idx;
      cmd.len      = len_w;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.action)
                  ACT_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_value_in = '0;
                     rsp_ok_in    = ins_ok;
                     if (ins_ok) begin
                        cmd.op       = CELL_INSERT;
                        length_in    = length_ff + 1'b1;
                        rsp_count_in = PLI_COUNT_W'(length_ff + 1'b1);
                     end else begin
                        rsp_count_in = PLI_COUNT_W'(length_ff);
                     end
                  end
                  ACT_DELETE: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_ok_in    = del_ok;
                     if (del_ok) begin
                        cmd.op       = CELL_DELETE;
                        length_in    = length_ff - 1'b1;
                        rsp_value_in = PLI_VALUE_W'(signed'(removed));
                        rsp_count_in = PLI_COUNT_W'(length_ff - 1'b1);
                     end else begin
                        rsp_value_in = '0;
                        rsp_count_in = PLI_COUNT_W'(length_ff);
                     end
                  end
                  ACT_PRINT: begin
                     // empty list prints nothing
                     if (length_ff != '0) begin
                        state_in   = ST_PRINT;
                        prn_cnt_in = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_value_in = '0;
                     rsp_count_in = PLI_COUNT_W'(length_ff);
                  end
               endcase
            end
         end
         ST_PRINT: begin
            // emit the head and rotate the used part of the chain
            if (slot_free) begin
               cmd.op       = CELL_ROTATE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_value_in = PLI_VALUE_W'(signed'(cell_data[0]));
               rsp_count_in = PLI_COUNT_W'(length_ff);
               rsp_last_in  = prn_last;
               prn_cnt_in   = prn_cnt_ff + 1'b1;
               if (prn_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         prn_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         prn_cnt_ff   <= prn_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.ok        = rsp_ok_ff;
   assign rsp_ch.value_out = rsp_value_ff;
   assign rsp_ch.count     = rsp_count_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_w;
      logic [ELEM_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = new_elem;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end

      pli_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .IDX        (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_data   (new_elem),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[i])
      );
   end

`ifndef SYNTHESIS
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LW'(CAPACITY))
      else $error("list length beyond capacity");

   a_print_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> !req_ch.ready)
      else $error("request taken during print");

   a_print_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (prn_cnt_ff < length_ff))
      else $error("print counter ran past length");

   a_ins_len: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.action == ACT_INSERT) && ins_ok)
      |=> (length_ff == $past(length_ff) + 1'b1))
      else $error("insert did not grow the list");
`endif

endmodule

`default_nettype wire

// ===== verif/pli_tb_pkg.sv =====
// testbench codes and the response word layout shared by checker and stimulus
`timescale 1ns / 1ps

package pli_tb_pkg;
   import pli_pkg::*;

   // action code the block has no operation for
   localparam action_type ACT_UNUSED = 2'd3;

   // one response word as the checker expects it
   typedef struct packed {
      logic                          ok;
      logic signed [PLI_VALUE_W-1:0] value_out;
      logic [PLI_COUNT_W-1:0]        count;
      logic                          last;
   } rsp_word_type;

endpackage

// ===== verif/pli_list_checker.sv =====
// list predictor and response checker watching both channels of the block
`timescale 1ns / 1ps

module pli_list_checker (
   input  logic clock,
   input  logic reset,
   pli_req_if   req_mon,
   pli_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   item_count,
   output int   result_count,
   output int   full_reject_count
);
   import pli_pkg::*;
   import pli_tb_pkg::*;

   // predicted list contents and length
   logic signed [PLI_ELEM_WIDTH-1:0] cells [PLI_CAPACITY];
   int                               list_len;

   // response words still owed by the block, oldest first
   rsp_word_type owed_words[$];

   // queue one expected word
   task automatic owe_word(input logic ok, input logic signed [PLI_VALUE_W-1:0] v,
                           input logic last);
      rsp_word_type w;
      w.ok        = ok;
      w.value_out = v;
      w.count     = list_len[PLI_COUNT_W-1:0];
      w.last      = last;
      owed_words.push_back(w);
   endtask

   // apply one request word to the predicted list
   task automatic list_apply(input action_type act, input logic [PLI_POS_W-1:0] position,
                             input logic signed [PLI_VALUE_W-1:0] v);
      int                               p;
      int                               k;
      logic signed [PLI_ELEM_WIDTH-1:0] removed;
      logic signed [PLI_VALUE_W-1:0]    shown;
      p = position;
      case (act)
         ACT_INSERT: begin
            if (p < 1 || p > list_len + 1 || list_len >= PLI_CAPACITY) begin
               if (list_len >= PLI_CAPACITY && p >= 1 && p <= list_len + 1)
                  full_reject_count++;
               owe_word(1'b0, '0, 1'b1);
            end else begin
               for (k = list_len; k >= p; k--)
                  cells[k] = cells[k-1];
               cells[p-1] = v;
               list_len++;
               owe_word(1'b1, '0, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (p < 1 || p > list_len) begin
               owe_word(1'b0, '0, 1'b1);
            end else begin
               removed = cells[p-1];
               for (k = p; k < list_len; k++)
                  cells[k-1] = cells[k];
               list_len--;
               shown = removed;
               owe_word(1'b1, shown, 1'b1);
            end
         end
         ACT_PRINT: begin
            // empty list gives no word at all
            for (k = 0; k < list_len; k++) begin
               shown = cells[k];
               owe_word(1'b1, shown, k == list_len - 1);
            end
         end
         default: owe_word(1'b0, '0, 1'b1);
      endcase
   endtask

   task automatic report_failure(input string what, input rsp_word_type want,
                                 input rsp_word_type got);
      string want_s;
      string got_s;
      want_s = $sformatf("ok=%0b value=%0d count=%0d last=%0b",
                         want.ok, want.value_out, want.count, want.last);
      got_s  = $sformatf("ok=%0b value=%0d count=%0d last=%0b",
                         got.ok, got.value_out, got.count, got.last);
      if (fail_count < 10)
         $display("%t %s: expected %s, got %s", $realtime, what, want_s, got_s);
      fail_count++;
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         list_len = 0;
         owed_words.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            item_count++;
            list_apply(req_mon.action, req_mon.position, req_mon.value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            got.ok        = rsp_mon.ok;
            got.value_out = rsp_mon.value_out;
            got.count     = rsp_mon.count;
            got.last      = rsp_mon.last;
            if (owed_words.size() == 0) begin
               want = '0;
               report_failure("unexpected word", want, got);
            end else begin
               want = owed_words.pop_front();
               if (got.ok !== want.ok || got.value_out !== want.value_out ||
                   got.count !== want.count || got.last !== want.last)
                  report_failure("mismatch", want, got);
            end
         end
      end
      pending = owed_words.size();
   end

endmodule

// ===== verif/positional_list_insert_delete_tb.sv =====
// stimulus, flow control and verdict for the positional list block
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;
   import pli_pkg::*;
   import pli_tb_pkg::*;

   localparam logic signed [PLI_VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [PLI_VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int LONG_HOLD      = 200;
   localparam int PHASE_ITEMS    = 90;

   logic clock;
   logic reset;

   int idle_pct;
   int stall_pct;
   int hold_asks;
   int shadow_len;

   int fail_count;
   int pending;
   int item_count;
   int result_count;
   int full_reject_count;

   pli_req_if req_ch ();
   pli_rsp_if rsp_ch ();

   positional_list_insert_delete u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pli_list_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .fail_count        (fail_count),
      .pending           (pending),
      .item_count        (item_count),
      .result_count      (result_count),
      .full_reject_count (full_reject_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the block hangs
   initial begin
      #5_000_000;
      $display("timeout after %0d requests", item_count);
      $display("status: fail");
      $finish;
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left    = 0;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one request word and wait until it is taken
   task automatic send_word(input action_type act, input int position,
                            input logic signed [PLI_VALUE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.action   = act;
      req_ch.position = position[PLI_POS_W-1:0];
      req_ch.value    = v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // track length only to aim positions
      if (act == ACT_INSERT && position >= 1 && position <= shadow_len + 1 &&
          shadow_len < PLI_CAPACITY)
         shadow_len++;
      else if (act == ACT_DELETE && position >= 1 && position <= shadow_len)
         shadow_len--;
      @(negedge clock);
   endtask

   // one random request, biased to grow or to drain the list
   task automatic random_word(input bit growing);
      int                            r;
      int                            position;
      action_type                    act;
      logic signed [PLI_VALUE_W-1:0] v;
      r = $urandom_range(99);
      if (r < 5)
         act = ACT_UNUSED;
      else if (r < 15)
         act = ACT_PRINT;
      else if (r < (growing ? 75 : 35))
         act = ACT_INSERT;
      else
         act = ACT_DELETE;
      // mostly legal positions, some anywhere in the field
      if ($urandom_range(9) < 8 && act == ACT_INSERT)
         position = $urandom_range(shadow_len + 1, 1);
      else if ($urandom_range(9) < 8 && act == ACT_DELETE && shadow_len > 0)
         position = $urandom_range(shadow_len, 1);
      else
         position = $urandom_range(31, 0);
      case ($urandom_range(19))
         0:       v = VAL_MIN;
         1:       v = VAL_MAX;
         2:       v = '0;
         3:       v = '1;
         default: v = $urandom;
      endcase
      send_word(act, position, v);
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;
      idle_pct        = 0;
      stall_pct       = 0;
      hold_asks       = 0;
      shadow_len      = 0;
      reset           = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, bad positions, both ends, extremes, unused code
      send_word(ACT_PRINT, 1, '0);
      send_word(ACT_DELETE, 1, '0);
      send_word(ACT_INSERT, 0, 32'sd5);
      send_word(ACT_INSERT, 2, 32'sd6);
      send_word(ACT_INSERT, 1, VAL_MAX);
      send_word(ACT_INSERT, 1, VAL_MIN);
      send_word(ACT_INSERT, 3, '0);
      send_word(ACT_INSERT, 2, '1);
      send_word(ACT_UNUSED, 31, VAL_MAX);
      send_word(ACT_PRINT, 31, VAL_MIN);
      send_word(ACT_INSERT, 31, 32'sd7);
      send_word(ACT_DELETE, 0, '0);
      send_word(ACT_DELETE, 5, '0);
      send_word(ACT_DELETE, 4, '0);
      send_word(ACT_DELETE, 1, '0);
      send_word(ACT_PRINT, 0, '0);
      send_word(ACT_DELETE, 2, '0);
      send_word(ACT_DELETE, 1, '0);
      send_word(ACT_DELETE, 1, '0);
      send_word(ACT_PRINT, 16, '0);

      // random: four flow-control phases, alternating fill and drain
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 82; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off while the sender keeps offering
            if (phase == 0 && i == 30)
               hold_asks++;
            random_word((i / 45) % 2 == 0);
         end
      end
      req_ch.valid = 1'b0;

      // drain, then a short quiet tail
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d requests and %0d response words, %0d inserts refused on a full list",
               item_count, result_count, full_reject_count);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures, %0d words never arrived", fail_count, pending);
         $display("status: fail");
      end
      $finish;
   end

endmodule
